>>> rtl/gtht_pkg.sv
// Shared types and constants for the generation-tagged handle table.
// Used by gtht_ctrl, gtht_dp and generation_tagged_handle_table_top.
package gtht_pkg;

	localparam int SLOTS      = 128;
	localparam int GEN_BITS   = 16;
	localparam int COUNT_BITS = 16;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int WALK_W = $clog2(SLOTS + 1);

	// Handle layout: generation in [31:16], slot + 1 in [15:8], zero low byte
	localparam int HANDLE_W = 32;
	localparam int HGEN_W   = 16;
	localparam int ENC_W    = 8;
	localparam int LOW_W    = 8;

	// Result field widths
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 2;
	localparam int SIDX_W   = 7;
	localparam int CNT_W    = 16;

	localparam int S_TUSER_W = CMD_W;
	localparam int S_TDATA_W = HANDLE_W;
	localparam int M_TUSER_W = STATUS_W;
	localparam int M_FLD_W   = HANDLE_W + SIDX_W + CNT_W;
	localparam int M_TDATA_W = ((M_FLD_W + 7) / 8) * 8;

	// Two-level search tree over the slot flags
	localparam int GRP    = 8;
	localparam int GRP_IW = $clog2(GRP);
	localparam int NGRP   = (SLOTS + GRP - 1) / GRP;
	localparam int GIDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE    = 3'd0,
		CMD_DELETE    = 3'd1,
		CMD_CHECK     = 3'd2,
		CMD_NOTIFY    = 3'd3,
		CMD_DRAIN     = 3'd4,
		CMD_RESET_ALL = 3'd5
	} cmd_e_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2,
		ST_NONE    = 2'd3
	} status_e_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic pick;
		logic walk_start;
		logic walk_en;
		logic exec;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic walk_done;
		logic out_free;
	} ctl_stat_t;

endpackage

>>> rtl/gtht_ctrl.sv
// Sequencing state machine of the handle table.
// Depends on gtht_pkg; drives gtht_dp through ctl_cmd_t.
module gtht_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [gtht_pkg::CMD_W-1:0]    in_cmd,
	output logic                          in_ready,
	input  gtht_pkg::ctl_stat_t           stat,
	output gtht_pkg::ctl_cmd_t            ctl
);
	import gtht_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_PICK,
		S_RD,
		S_WALK,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_ready && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (cmd_e_t'(in_cmd))
							CMD_CREATE, CMD_DRAIN:               state_q <= S_SRCH;
							CMD_DELETE, CMD_CHECK, CMD_NOTIFY:   state_q <= S_RD;
							CMD_RESET_ALL:                       state_q <= S_WALK;
							default:                             state_q <= S_EXEC;
						endcase
					end
				end
				S_SRCH: state_q <= S_PICK;
				S_PICK: state_q <= S_RD;
				S_RD:   state_q <= S_EXEC;
				S_WALK: begin
					if (stat.walk_done) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl            = '0;
		ctl.accept     = accept;
		ctl.walk_start = accept && (cmd_e_t'(in_cmd) == CMD_RESET_ALL);
		ctl.pick       = (state_q == S_PICK);
		ctl.walk_en    = (state_q == S_WALK);
		ctl.exec       = (state_q == S_EXEC) && stat.out_free;
	end

endmodule

>>> rtl/gtht_dp.sv
// Datapath of the handle table: slot flags, generation and count memories,
// free/pending search tree, command execution and the result register.
// Depends on gtht_pkg; controlled by gtht_ctrl.
module gtht_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  gtht_pkg::ctl_cmd_t               ctl,
	output gtht_pkg::ctl_stat_t              stat,
	input  logic [gtht_pkg::CMD_W-1:0]       in_cmd,
	input  logic [gtht_pkg::HANDLE_W-1:0]    in_handle,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [gtht_pkg::STATUS_W-1:0]    out_status,
	output logic [gtht_pkg::HANDLE_W-1:0]    out_handle,
	output logic [gtht_pkg::SIDX_W-1:0]      out_slot,
	output logic [gtht_pkg::CNT_W-1:0]       out_count
);
	import gtht_pkg::*;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// Latched word
	cmd_e_t                cmd_q;
	logic [HANDLE_W-1:0]   handle_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  fmt_ok_q;
	logic                  found_q;

	// Per-slot flags
	logic [SLOTS-1:0]      active_q;
	logic [SLOTS-1:0]      pend_nz_q;
	logic [SLOTS-1:0]      gen_vld_q;

	// Memories
	logic [GEN_BITS-1:0]   gen_mem [SLOTS];
	logic [COUNT_BITS-1:0] cnt_mem [SLOTS];
	logic [GEN_BITS-1:0]   gen_rdata_q;
	logic [COUNT_BITS-1:0] cnt_rdata_q;
	logic                  gen_vld_rd_q;
	logic                  cnt_nz_rd_q;
	logic [SLOT_W-1:0]     rd_addr;

	// Generation walk for reset_all
	logic [WALK_W-1:0]     walk_q;
	logic                  walk_vld_s1;
	logic [SLOT_W-1:0]     walk_addr_s1;

	// Search tree
	logic [NGRP*GRP-1:0]   srch_vec;
	logic [NGRP-1:0]       grp_any_s1;
	logic [GRP_IW-1:0]     grp_idx_s1 [NGRP];
	logic                  pick_found;
	logic [SLOT_W-1:0]     pick_slot;

	// Result register
	logic                  out_valid_q;
	status_e_t             out_status_q;
	logic [HANDLE_W-1:0]   out_handle_q;
	logic [SIDX_W-1:0]     out_slot_q;
	logic [CNT_W-1:0]      out_count_q;

	// Execution
	logic [ENC_W-1:0]      in_enc;
	logic                  in_fmt_ok;
	logic [SLOT_W-1:0]     in_slot;
	logic [GEN_BITS-1:0]   eff_gen;
	logic [COUNT_BITS-1:0] eff_cnt;
	logic [GEN_BITS-1:0]   new_gen;
	logic [COUNT_BITS-1:0] inc_cnt;
	logic                  hvalid;
	logic                  act_set, act_clr, nz_set, nz_clr, gen_wr, cnt_wr;
	status_e_t             res_status;
	logic [HANDLE_W-1:0]   res_handle;
	logic [SIDX_W-1:0]     res_slot;
	logic [CNT_W-1:0]      res_count;
	logic                  gen_we;
	logic [SLOT_W-1:0]     gen_waddr;
	logic [GEN_BITS-1:0]   gen_wdata;

	function automatic logic [GRP_IW-1:0] low_idx(input logic [GRP-1:0] v);
		logic [GRP_IW-1:0] r;
		r = '0;
		for (int i = GRP - 1; i >= 0; i--) begin
			if (v[i]) r = GRP_IW'(i);
		end
		return r;
	endfunction

	function automatic logic [HANDLE_W-1:0] make_handle(input logic [SLOT_W-1:0] s,
			input logic [GEN_BITS-1:0] g);
		logic [SLOT_W:0] enc;
		enc = {1'b0, s} + 1'b1;
		return {HGEN_W'(g), ENC_W'(enc), LOW_W'(0)};
	endfunction

	// Decode the incoming handle
	assign in_enc    = in_handle[LOW_W +: ENC_W];
	assign in_fmt_ok = (in_handle[LOW_W-1:0] == '0) && (in_enc != '0)
		&& (in_enc <= ENC_W'(SLOTS));
	assign in_slot   = SLOT_W'(in_enc - 1'b1);

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q    <= cmd_e_t'(in_cmd);
			handle_q <= in_handle;
			fmt_ok_q <= in_fmt_ok;
			slot_q   <= in_slot;
		end else if (ctl.pick) begin
			slot_q   <= pick_slot;
			found_q  <= pick_found;
		end
	end

	// Lowest free slot for create, lowest pending slot for drain
	always_comb begin
		srch_vec = '0;
		for (int i = 0; i < SLOTS; i++) begin
			srch_vec[i] = (cmd_q == CMD_CREATE) ? ~active_q[i] : pend_nz_q[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP; g++) begin
			grp_any_s1[g] <= |srch_vec[g*GRP +: GRP];
			grp_idx_s1[g] <= low_idx(srch_vec[g*GRP +: GRP]);
		end
	end

	always_comb begin
		pick_found = 1'b0;
		pick_slot  = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				pick_found = 1'b1;
				pick_slot  = SLOT_W'({GIDX_W'(g), grp_idx_s1[g]});
			end
		end
	end

	// Memory read port
	assign rd_addr = ctl.walk_en ? walk_q[SLOT_W-1:0] : slot_q;

	always_ff @(posedge clk) begin
		if (gen_we) gen_mem[gen_waddr] <= gen_wdata;
		gen_rdata_q  <= gen_mem[rd_addr];
		gen_vld_rd_q <= gen_vld_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.exec && cnt_wr) cnt_mem[slot_q] <= inc_cnt;
		cnt_rdata_q <= cnt_mem[rd_addr];
		cnt_nz_rd_q <= pend_nz_q[rd_addr];
	end

	// Unwritten generations, and counts of slots without the pending flag, read as zero
	assign eff_gen = gen_vld_rd_q ? gen_rdata_q : '0;
	assign eff_cnt = cnt_nz_rd_q ? cnt_rdata_q : '0;

	assign new_gen = ((GEN_BITS'(eff_gen + 1'b1)) == '0) ? GEN_BITS'(1) :
		GEN_BITS'(eff_gen + 1'b1);
	assign inc_cnt = (eff_cnt == COUNT_MAX) ? eff_cnt : COUNT_BITS'(eff_cnt + 1'b1);
	assign hvalid  = fmt_ok_q && active_q[slot_q]
		&& (handle_q[HANDLE_W-1 -: HGEN_W] == HGEN_W'(eff_gen));

	always_comb begin
		res_status = ST_INVALID;
		res_handle = '0;
		res_slot   = '0;
		res_count  = '0;
		act_set    = 1'b0;
		act_clr    = 1'b0;
		nz_set     = 1'b0;
		nz_clr     = 1'b0;
		gen_wr     = 1'b0;
		cnt_wr     = 1'b0;
		case (cmd_q)
			CMD_CREATE: begin
				if (found_q) begin
					res_status = ST_OK;
					res_handle = make_handle(slot_q, new_gen);
					res_slot   = SIDX_W'(slot_q);
					act_set    = 1'b1;
					nz_clr     = 1'b1;
					gen_wr     = 1'b1;
				end else begin
					res_status = ST_FULL;
				end
			end
			CMD_DELETE: begin
				if (hvalid) begin
					res_status = ST_OK;
					res_slot   = SIDX_W'(slot_q);
					act_clr    = 1'b1;
					nz_clr     = 1'b1;
				end
			end
			CMD_CHECK: begin
				if (hvalid) begin
					res_status = ST_OK;
					res_slot   = SIDX_W'(slot_q);
				end
			end
			CMD_NOTIFY: begin
				if (hvalid) begin
					res_status = ST_OK;
					res_slot   = SIDX_W'(slot_q);
					res_count  = CNT_W'(inc_cnt);
					nz_set     = 1'b1;
					cnt_wr     = 1'b1;
				end
			end
			CMD_DRAIN: begin
				if (found_q) begin
					res_status = ST_OK;
					res_handle = make_handle(slot_q, eff_gen);
					res_slot   = SIDX_W'(slot_q);
					res_count  = CNT_W'(eff_cnt);
					nz_clr     = 1'b1;
				end else begin
					res_status = ST_NONE;
				end
			end
			CMD_RESET_ALL: begin
				res_status = ST_OK;
			end
			default: begin
				res_status = ST_INVALID;
			end
		endcase
	end

	// Generation write: walk increment or create
	always_comb begin
		gen_we    = 1'b0;
		gen_waddr = slot_q;
		gen_wdata = new_gen;
		if (walk_vld_s1) begin
			gen_we    = 1'b1;
			gen_waddr = walk_addr_s1;
			gen_wdata = GEN_BITS'(eff_gen + 1'b1);
		end else if (ctl.exec && gen_wr) begin
			gen_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			pend_nz_q   <= '0;
			gen_vld_q   <= '0;
			walk_q      <= '0;
			walk_vld_s1 <= 1'b0;
		end else begin
			if (ctl.walk_start) begin
				active_q  <= '0;
				pend_nz_q <= '0;
				walk_q    <= '0;
			end else if (ctl.exec) begin
				if (act_set) active_q[slot_q]  <= 1'b1;
				if (act_clr) active_q[slot_q]  <= 1'b0;
				if (nz_set)  pend_nz_q[slot_q] <= 1'b1;
				if (nz_clr)  pend_nz_q[slot_q] <= 1'b0;
			end
			if (gen_we) gen_vld_q[gen_waddr] <= 1'b1;
			walk_vld_s1 <= ctl.walk_en && (walk_q < WALK_W'(SLOTS));
			if (ctl.walk_en && (walk_q < WALK_W'(SLOTS))) walk_q <= WALK_W'(walk_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		walk_addr_s1 <= walk_q[SLOT_W-1:0];
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			out_status_q <= res_status;
			out_handle_q <= res_handle;
			out_slot_q   <= res_slot;
			out_count_q  <= res_count;
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.walk_done = (walk_q == WALK_W'(SLOTS)) && !walk_vld_s1;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_handle = out_handle_q;
	assign out_slot   = out_slot_q;
	assign out_count  = out_count_q;

`ifndef SYNTHESIS
	a_create_sets_active: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec && (cmd_q == CMD_CREATE) && found_q |=> active_q[$past(slot_q)])
		else $error("created slot not marked active");

	a_pending_only_active: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_nz_q & ~active_q) == '0)
		else $error("pending count on a free slot");

	a_walk_all_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.walk_en |-> (active_q == '0) && (pend_nz_q == '0))
		else $error("slot active during generation walk");

	a_full_only_create: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec && (res_status == ST_FULL) |-> (cmd_q == CMD_CREATE))
		else $error("table full reported for a non-create word");
`endif

endmodule

>>> rtl/generation_tagged_handle_table_top.sv
// Top level of the generation-tagged handle table.
// Depends on gtht_pkg, gtht_ctrl and gtht_dp.

// Handle table with 128 slots, each with an active flag, a 16-bit generation
// and a 16-bit pending count. One command word is taken at a time. Delete,
// check and notify go through accept, registered memory read and execute;
// create and drain add the registered two-level lowest-set-bit search over
// the slot flags before the read. Reset_all walks the generation memory one
// slot per cycle. The result sits in an output register, so the next word
// is accepted while a result still waits to be taken. Out-of-range command
// codes return invalid handle.
module generation_tagged_handle_table_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [gtht_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // [31:0] handle
	input  logic [gtht_pkg::S_TUSER_W-1:0]    s_axis_tuser,   // [2:0] cmd
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [gtht_pkg::M_TDATA_W-1:0]    m_axis_tdata,   // [31:0] handle_out,
	                                                          // [38:32] slot_index,
	                                                          // [54:39] pending_count
	output logic [gtht_pkg::M_TUSER_W-1:0]    m_axis_tuser    // [1:0] status
);
	import gtht_pkg::*;

	ctl_cmd_t             ctl;
	ctl_stat_t            stat;
	logic [HANDLE_W-1:0]  out_handle;
	logic [SIDX_W-1:0]    out_slot;
	logic [CNT_W-1:0]     out_count;

	gtht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_cmd   (s_axis_tuser),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	gtht_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.in_cmd     (s_axis_tuser),
		.in_handle  (s_axis_tdata),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_handle (out_handle),
		.out_slot   (out_slot),
		.out_count  (out_count)
	);

	// Pack result fields, lowest first, zero pad to whole bytes
	assign m_axis_tdata = M_TDATA_W'({out_count, out_slot, out_handle});

endmodule
